FILE: src/semi_lagrangian_grid_advect_assert.svh
// Assertion macros shared by the advection block. Both expect i_clk and
// i_rst_n in scope where they are used.
`ifndef SEMI_LAGRANGIAN_GRID_ADVECT_ASSERT_SVH
`define SEMI_LAGRANGIAN_GRID_ADVECT_ASSERT_SVH

// same-cycle implication
`define SLA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sla_pkg.sv
package sla_pkg;

    localparam int MAX_GRID   = 128;
    localparam int STRIDE     = MAX_GRID + 2;
    localparam int BANK_SIDE  = (STRIDE + 1) / 2;
    localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int BANKS      = 4;

    localparam int CELL_W = 8;
    localparam int HALF_W = CELL_W - 1;
    localparam int VAL_W  = 32;
    localparam int FRAC_W = 16;
    localparam int POS_W  = CELL_W + FRAC_W;
    localparam int STEP_W = 24;
    localparam int PROD_W = STEP_W + 1 + VAL_W;
    localparam int OFF_W  = PROD_W - FRAC_W;
    localparam int DIFF_W = OFF_W + 1;
    localparam int WGT_W  = FRAC_W + 1;
    localparam int MAC_W  = WGT_W + 1 + VAL_W;

    localparam logic [0:0] OP_LOAD   = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;

    localparam logic [0:0] CFG_GRID_N     = 1'b0;
    localparam logic [0:0] CFG_STEP_SCALE = 1'b1;

    localparam logic [CELL_W-1:0] GRID_N_RESET = CELL_W'(64);

    localparam logic [WGT_W-1:0]         WGT_ONE  = WGT_W'(1) << FRAC_W;
    localparam logic signed [PROD_W-1:0] RND_PROD = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [MAC_W-1:0]  RND_MAC  = MAC_W'(1) <<< (FRAC_W - 1);

    typedef struct packed {
        logic               en;
        logic               we;
        logic [BANK_AW-1:0] addr;
        logic [VAL_W-1:0]   wdata;
    } t_bank_req;

    typedef struct packed {
        logic              valid;
        logic              i0_odd;
        logic              j0_odd;
        logic [FRAC_W-1:0] s1;
        logic [FRAC_W-1:0] t1;
        logic [CELL_W-1:0] x;
        logic [CELL_W-1:0] y;
    } t_smp;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic [CELL_W-1:0]       x;
        logic [CELL_W-1:0]       y;
    } t_res;

    // word address inside one parity bank
    function automatic logic [BANK_AW-1:0] bank_addr(input logic [HALF_W-1:0] col,
                                                      input logic [HALF_W-1:0] row);
        return BANK_AW'(row) * BANK_AW'(BANK_SIDE) + BANK_AW'(col);
    endfunction

endpackage

FILE: src/semi_lagrangian_grid_advect.sv
// Semi-Lagrangian advection with bilinear sampling, Q16.16. Load beats
// (tuser = 0) write one source cell; sample beats (tuser = 1) trace the cell
// back by step_scale * velocity, clamp to [0.5, n+0.5] and return the blend
// of the four surrounding cells. Loads and samples may be mixed freely and
// one beat is taken every cycle: the source field sits in four single-port
// banks split by column and row parity, so each beat needs at most one
// access per bank. A sample's result passes the trace stages, the bank read,
// the blend stages and the output register; loads give no result. The input
// is held off only while the output skid register holds a beat: from the
// cycle it fills under backpressure until the cycle after the master side
// takes the beat ahead of it. Cells must be loaded before any sample reaches
// them. Write configuration only while the pipeline is empty.
`include "semi_lagrangian_grid_advect_assert.svh"

module semi_lagrangian_grid_advect
    import sla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // stream in
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [111:0]        i_s_tdata,   // cell_x, cell_y, load_value, vel_x, vel_y
    input  logic [0:0]          i_s_tuser,   // opcode
    // stream out
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [47:0]         o_m_tdata,   // advected_value, result_x, result_y
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [STEP_W-1:0]   i_cfg_data
);

    logic [CELL_W-1:0]            r_grid_n;
    logic [STEP_W-1:0]            r_step_scale;
    logic                         r_out_valid, r_skid_valid;
    t_res                         r_out, r_skid;

    logic                         w_adv;
    t_bank_req [BANKS-1:0]        w_bank_req;
    logic [BANKS-1:0][VAL_W-1:0]  w_rdata;
    logic [BANKS-1:0]             w_we_vec;
    t_smp                         w_smp;
    t_res                         w_res;

    function automatic logic [CELL_W-1:0] sat_grid(input logic [CELL_W-1:0] v);
        if (v == '0) begin
            return CELL_W'(1);
        end else if (v > CELL_W'(MAX_GRID)) begin
            return CELL_W'(MAX_GRID);
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n     <= GRID_N_RESET;
            r_step_scale <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_N:     r_grid_n     <= sat_grid(i_cfg_data[CELL_W-1:0]);
                CFG_STEP_SCALE: r_step_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the skid register is holding a beat
    assign w_adv      = !r_skid_valid;
    assign o_s_tready = w_adv;

    sla_trace u_trace (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (i_s_tvalid),
        .i_op         (i_s_tuser[0]),
        .i_x          (i_s_tdata[7:0]),
        .i_y          (i_s_tdata[15:8]),
        .i_load_value (i_s_tdata[47:16]),
        .i_vel_x      ($signed(i_s_tdata[79:48])),
        .i_vel_y      ($signed(i_s_tdata[111:80])),
        .i_grid_n     (r_grid_n),
        .i_step_scale (r_step_scale),
        .o_bank_req   (w_bank_req),
        .o_smp        (w_smp)
    );

    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        sla_bank u_bank (
            .i_clk   (i_clk),
            .i_req   (w_bank_req[g]),
            .o_rdata (w_rdata[g])
        );
    end

    sla_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_smp   (w_smp),
        .i_rdata (w_rdata),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= w_res.valid;
        end else if (w_res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.y, r_out.x, r_out.value};

    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            w_we_vec[b] = w_bank_req[b].en && w_bank_req[b].we;
        end
    end

    `SLA_ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `SLA_ASSERT_IMPLY(a_grid_n_range, 1'b1, (r_grid_n != '0) && (r_grid_n <= CELL_W'(MAX_GRID)), "grid_n out of range")
    `SLA_ASSERT_IMPLY(a_single_write, 1'b1, $onehot0(w_we_vec), "load wrote more than one bank")
    `SLA_ASSERT_NEXT(a_park_in_skid, r_out_valid && !i_m_tready && w_res.valid && !r_skid_valid, r_skid_valid, "result beat lost under backpressure")

endmodule

FILE: src/sla_bank.sv
module sla_bank
    import sla_pkg::*;
(
    input  logic             i_clk,
    input  t_bank_req        i_req,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [BANK_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sla_trace.sv
module sla_trace
    import sla_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic                          i_op,
    input  logic [CELL_W-1:0]             i_x,
    input  logic [CELL_W-1:0]             i_y,
    input  logic [VAL_W-1:0]              i_load_value,
    input  logic signed [VAL_W-1:0]       i_vel_x,
    input  logic signed [VAL_W-1:0]       i_vel_y,
    input  logic [CELL_W-1:0]             i_grid_n,
    input  logic [STEP_W-1:0]             i_step_scale,
    output t_bank_req [BANKS-1:0]         o_bank_req,
    output t_smp                          o_smp
);

    // stage 1: back-trace products
    logic                     r1_valid;
    logic                     r1_op;
    logic [CELL_W-1:0]        r1_x, r1_y;
    logic [VAL_W-1:0]         r1_val;
    logic signed [PROD_W-1:0] r1_prod_x, r1_prod_y;
    // stage 2: rounded offsets
    logic                     r2_valid;
    logic                     r2_op;
    logic [CELL_W-1:0]        r2_x, r2_y;
    logic [VAL_W-1:0]         r2_val;
    logic signed [OFF_W-1:0]  r2_off_x, r2_off_y;
    // stage 3: clamped positions, drives the bank ports
    logic                     r3_valid;
    logic                     r3_op;
    logic [CELL_W-1:0]        r3_x, r3_y;
    logic [VAL_W-1:0]         r3_val;
    logic [POS_W-1:0]         r3_px, r3_py;

    logic signed [DIFF_W-1:0] n_diff_x, n_diff_y, w_hi;
    logic [POS_W-1:0]         n_px, n_py;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [DIFF_W-1:0] d,
                                                   input logic signed [DIFF_W-1:0] hi);
        logic signed [DIFF_W-1:0] lo;
        lo = DIFF_W'(1) <<< (FRAC_W - 1);
        if (d < lo) begin
            return POS_W'(lo);
        end else if (d > hi) begin
            return POS_W'(hi);
        end
        return POS_W'(d);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_op     <= i_op;
            r1_x      <= i_x;
            r1_y      <= i_y;
            r1_val    <= i_load_value;
            r1_prod_x <= $signed({1'b0, i_step_scale}) * i_vel_x;
            r1_prod_y <= $signed({1'b0, i_step_scale}) * i_vel_y;

            r2_op     <= r1_op;
            r2_x      <= r1_x;
            r2_y      <= r1_y;
            r2_val    <= r1_val;
            r2_off_x  <= OFF_W'((r1_prod_x + RND_PROD) >>> FRAC_W);
            r2_off_y  <= OFF_W'((r1_prod_y + RND_PROD) >>> FRAC_W);

            r3_op     <= r2_op;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
            r3_val    <= r2_val;
            r3_px     <= n_px;
            r3_py     <= n_py;
        end
    end

    always_comb begin
        w_hi = $signed({{(DIFF_W - POS_W){1'b0}}, i_grid_n, 1'b1, {(FRAC_W - 1){1'b0}}});
        n_diff_x = $signed({{(DIFF_W - POS_W){1'b0}}, r2_x, {FRAC_W{1'b0}}})
                 - DIFF_W'(r2_off_x);
        n_diff_y = $signed({{(DIFF_W - POS_W){1'b0}}, r2_y, {FRAC_W{1'b0}}})
                 - DIFF_W'(r2_off_y);
        n_px = clamp_pos(n_diff_x, w_hi);
        n_py = clamp_pos(n_diff_y, w_hi);
    end

    // Bank {row parity, column parity}. A sample reads all four banks; the
    // neighbor of matching parity sits at i0 or i0+1.
    always_comb begin
        logic [CELL_W-1:0] i0, j0, col, row;
        logic              bx, by, in_range;
        i0 = r3_px[POS_W-1:FRAC_W];
        j0 = r3_py[POS_W-1:FRAC_W];
        in_range = (r3_x < CELL_W'(STRIDE)) && (r3_y < CELL_W'(STRIDE));
        for (int b = 0; b < BANKS; b++) begin
            bx  = 1'(b);
            by  = 1'(b >> 1);
            col = i0 + CELL_W'(i0[0] ^ bx);
            row = j0 + CELL_W'(j0[0] ^ by);
            o_bank_req[b].wdata = r3_val;
            if (r3_op == OP_LOAD) begin
                o_bank_req[b].we   = 1'b1;
                o_bank_req[b].en   = i_adv && r3_valid && in_range
                                   && (r3_x[0] == bx) && (r3_y[0] == by);
                o_bank_req[b].addr = bank_addr(r3_x[CELL_W-1:1], r3_y[CELL_W-1:1]);
            end else begin
                o_bank_req[b].we   = 1'b0;
                o_bank_req[b].en   = i_adv && r3_valid;
                o_bank_req[b].addr = bank_addr(col[CELL_W-1:1], row[CELL_W-1:1]);
            end
        end
    end

    always_comb begin
        o_smp.valid  = r3_valid && (r3_op == OP_SAMPLE);
        o_smp.i0_odd = r3_px[FRAC_W];
        o_smp.j0_odd = r3_py[FRAC_W];
        o_smp.s1     = r3_px[FRAC_W-1:0];
        o_smp.t1     = r3_py[FRAC_W-1:0];
        o_smp.x      = r3_x;
        o_smp.y      = r3_y;
    end

endmodule

FILE: src/sla_blend.sv
module sla_blend
    import sla_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  t_smp                         i_smp,
    input  logic [BANKS-1:0][VAL_W-1:0]  i_rdata,
    output t_res                         o_res
);

    // stage 4 lines up with the registered bank read data
    t_smp                    r4_smp;
    logic                    r5_valid, r6_valid, r7_valid;
    logic [FRAC_W-1:0]       r5_s1, r6_s1;
    logic [CELL_W-1:0]       r5_x, r5_y, r6_x, r6_y, r7_x, r7_y;
    logic signed [MAC_W-1:0] r5_pa, r5_pb, r5_pc, r5_pd;
    logic signed [VAL_W-1:0] r6_c0, r6_c1;
    logic signed [MAC_W-1:0] r7_q0, r7_q1;

    logic signed [VAL_W-1:0] w_a, w_b, w_c, w_d;
    logic [WGT_W-1:0]        w_t0, w_t1, w_s0, w_s1;

    always_comb begin
        w_a  = $signed(i_rdata[{r4_smp.j0_odd, r4_smp.i0_odd}]);
        w_b  = $signed(i_rdata[{~r4_smp.j0_odd, r4_smp.i0_odd}]);
        w_c  = $signed(i_rdata[{r4_smp.j0_odd, ~r4_smp.i0_odd}]);
        w_d  = $signed(i_rdata[{~r4_smp.j0_odd, ~r4_smp.i0_odd}]);
        w_t1 = {1'b0, r4_smp.t1};
        w_t0 = WGT_ONE - w_t1;
        w_s1 = {1'b0, r6_s1};
        w_s0 = WGT_ONE - w_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_smp.valid <= 1'b0;
            r5_valid     <= 1'b0;
            r6_valid     <= 1'b0;
            r7_valid     <= 1'b0;
        end else if (i_adv) begin
            r4_smp       <= i_smp;
            r5_valid     <= r4_smp.valid;
            r6_valid     <= r5_valid;
            r7_valid     <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // column blends, one weight per row pair
            r5_pa <= $signed({1'b0, w_t0}) * w_a;
            r5_pb <= $signed({1'b0, w_t1}) * w_b;
            r5_pc <= $signed({1'b0, w_t0}) * w_c;
            r5_pd <= $signed({1'b0, w_t1}) * w_d;
            r5_s1 <= r4_smp.s1;
            r5_x  <= r4_smp.x;
            r5_y  <= r4_smp.y;

            r6_c0 <= VAL_W'((r5_pa + r5_pb + RND_MAC) >>> FRAC_W);
            r6_c1 <= VAL_W'((r5_pc + r5_pd + RND_MAC) >>> FRAC_W);
            r6_s1 <= r5_s1;
            r6_x  <= r5_x;
            r6_y  <= r5_y;

            r7_q0 <= $signed({1'b0, w_s0}) * r6_c0;
            r7_q1 <= $signed({1'b0, w_s1}) * r6_c1;
            r7_x  <= r6_x;
            r7_y  <= r6_y;
        end
    end

    always_comb begin
        o_res.valid = r7_valid;
        o_res.value = VAL_W'((r7_q0 + r7_q1 + RND_MAC) >>> FRAC_W);
        o_res.x     = r7_x;
        o_res.y     = r7_y;
    end

endmodule
